>>> hdl/sgvs_pkg.sv
// Shared constants for the smoothing group vertex split unit.
`timescale 1ns / 1ps

package sgvs_pkg;

  localparam int unsigned INDEX_W = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned GROUP_W = 32;

  // Number of vertex slots, originals and copies together; port widths are set apart.
  localparam int unsigned VERTEX_SLOTS = 4096;

  // A face without a smoothing group is treated as belonging to the top group.
  localparam logic [GROUP_W-1:0] ZERO_GROUP = 32'h8000_0000;

endpackage

>>> hdl/smoothing_group_vertex_split_unit.sv
// Top level of the smoothing group vertex split unit.
`timescale 1ns / 1ps

// Remaps face corners to per-smoothing-group vertex copies.
// Input channel (in_valid/in_ready) carries one corner request: the original
// vertex_index and the face group_mask. Output channel (out_valid/out_ready)
// returns one result per request: mapped_index, new_copy, vertex_count and
// error_flag. num_verts is written through cfg_write_en/cfg_write_data; the
// user must write it only while the unit is idle, which the block does not enforce.
// Copy masks and chain links live in one single-port-write memory of
// 4096 words with a registered read. A request reads the entry of its
// original vertex, walks the chain until a mask matches and appends a new
// copy if the chain ends without a match; an out-of-range index skips both.
// The next request is taken as soon as the previous result is in the output
// register, so a stalled receiver holds at most one finished result; a
// further result waits inside the unit until out_ready frees the register.
// After reset the unit clears all 4096 memory entries, one entry per cycle,
// and accepts no request until the clear is done.
module smoothing_group_vertex_split_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [sgvs_pkg::COUNT_W-1:0]    cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sgvs_pkg::INDEX_W-1:0]    vertex_index,
  input  logic [sgvs_pkg::GROUP_W-1:0]    group_mask,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sgvs_pkg::INDEX_W-1:0]    mapped_index,
  output logic                            new_copy,
  output logic [sgvs_pkg::COUNT_W-1:0]    vertex_count,
  output logic                            error_flag
);

  localparam int unsigned DEPTH = sgvs_pkg::VERTEX_SLOTS;
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned NW = IW + 1;

  typedef struct packed {
    logic                            link_valid;
    logic [IW-1:0]                   link;
    logic [sgvs_pkg::GROUP_W-1:0]    mask;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_APPEND,
    ST_RESULT
  } state_t;

  state_t state;

  entry_t mem [DEPTH];
  entry_t rd_data;
  logic   mem_re;
  logic   [IW-1:0] rd_addr;
  logic   mem_we;
  logic   [IW-1:0] wr_addr;
  entry_t wr_data;

  logic [sgvs_pkg::COUNT_W-1:0] num_verts;
  logic [IW-1:0]                extra_copies;
  logic [IW-1:0]                clr_addr;
  logic [NW-1:0]                eff_nv;
  logic [NW-1:0]                count;

  logic [sgvs_pkg::GROUP_W-1:0] grp;
  logic [sgvs_pkg::GROUP_W-1:0] in_grp;
  logic [IW-1:0]                cur;
  logic [NW-1:0]                steps;

  logic [IW-1:0]                res_idx;
  logic                         res_new;
  logic [NW-1:0]                res_count;
  logic                         res_err;

  logic                         in_fire;
  logic                         index_bad;
  logic                         hit;
  logic                         table_full;

  // Register value zero counts as one vertex, values past the table as a full table.
  always_comb begin
    if (num_verts == '0) begin
      eff_nv = NW'(1);
    end else if (32'(num_verts) > 32'(DEPTH)) begin
      eff_nv = NW'(DEPTH);
    end else begin
      eff_nv = NW'(num_verts);
    end
  end

  assign count      = eff_nv + NW'(extra_copies);
  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_grp     = (group_mask == '0) ? sgvs_pkg::ZERO_GROUP : group_mask;
  assign index_bad  = 32'(vertex_index) >= 32'(eff_nv);
  assign hit        = |(rd_data.mask & grp);
  assign table_full = count >= NW'(DEPTH);

  // Memory port control.
  always_comb begin
    mem_re  = 1'b0;
    rd_addr = IW'(vertex_index);
    mem_we  = 1'b0;
    wr_addr = cur;
    wr_data = rd_data;
    unique case (state)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = '{link_valid: 1'b0, link: '0, mask: '1};
      end
      ST_IDLE: begin
        mem_re = in_fire && !index_bad;
      end
      ST_WALK: begin
        if (hit) begin
          mem_we       = 1'b1;
          wr_data.mask = rd_data.mask & grp;
        end else if (!rd_data.link_valid) begin
          mem_we             = !table_full;
          wr_data.link_valid = 1'b1;
          wr_data.link       = IW'(count);
        end else begin
          mem_re  = steps != NW'(DEPTH);
          rd_addr = rd_data.link;
        end
      end
      ST_APPEND: begin
        mem_we  = 1'b1;
        wr_addr = IW'(count);
        wr_data = '{link_valid: 1'b0, link: '0, mask: grp};
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      num_verts    <= sgvs_pkg::COUNT_W'(1);
      extra_copies <= '0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        num_verts <= cfg_write_data;
      end
      // In the result state the output register is reloaded below instead.
      if (out_valid && out_ready && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + IW'(1);
          if (clr_addr == IW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            grp       <= in_grp;
            cur       <= IW'(vertex_index);
            steps     <= '0;
            res_idx   <= '0;
            res_new   <= 1'b0;
            res_count <= count;
            res_err   <= 1'b1;
            state     <= index_bad ? ST_RESULT : ST_WALK;
          end
        end
        ST_WALK: begin
          if (hit) begin
            res_idx <= cur;
            res_err <= 1'b0;
            state   <= ST_RESULT;
          end else if (!rd_data.link_valid) begin
            // Chain ends without a match: append a copy unless the table is full.
            state <= table_full ? ST_RESULT : ST_APPEND;
          end else if (steps == NW'(DEPTH)) begin
            state <= ST_RESULT;
          end else begin
            cur   <= rd_data.link;
            steps <= steps + NW'(1);
          end
        end
        ST_APPEND: begin
          extra_copies <= extra_copies + IW'(1);
          res_idx      <= IW'(count);
          res_new      <= 1'b1;
          res_count    <= count + NW'(1);
          res_err      <= 1'b0;
          state        <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            mapped_index <= sgvs_pkg::INDEX_W'(res_idx);
            new_copy     <= res_new;
            vertex_count <= sgvs_pkg::COUNT_W'(32'(res_count));
            error_flag   <= res_err;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the smoothing group vertex split unit.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned INDEX_W = sgvs_pkg::INDEX_W;
  localparam int unsigned COUNT_W = sgvs_pkg::COUNT_W;
  localparam int unsigned GROUP_W = sgvs_pkg::GROUP_W;
  localparam int unsigned TABLE_DEPTH = sgvs_pkg::VERTEX_SLOTS;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex;
    logic [GROUP_W-1:0] group;
  } corner_t;

  typedef struct packed {
    logic [INDEX_W-1:0] mapped;
    logic               new_copy;
    logic [COUNT_W-1:0] count;
    logic               err;
  } remap_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [COUNT_W-1:0] cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [INDEX_W-1:0] vertex_index = '0;
  logic [GROUP_W-1:0] group_mask = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [INDEX_W-1:0] mapped_index;
  logic               new_copy;
  logic [COUNT_W-1:0] vertex_count;
  logic               error_flag;

  // Shadow copy of the unit's chain memory and counters.
  logic [GROUP_W-1:0] kept_mask [TABLE_DEPTH];
  logic [COUNT_W-1:0] next_copy [TABLE_DEPTH];
  bit                 link_ok [TABLE_DEPTH];
  logic [COUNT_W-1:0] spare_copies;
  logic [COUNT_W-1:0] num_verts_setting;

  corner_t     corners_to_send [$];
  remap_t      expected_remaps [$];
  corner_t     launch_corner;
  remap_t      oldest_remap;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  bit          hold_trigger = 1'b0;
  bit          long_hold = 1'b0;

  smoothing_group_vertex_split_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .vertex_index(vertex_index),
    .group_mask(group_mask),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mapped_index(mapped_index),
    .new_copy(new_copy),
    .vertex_count(vertex_count),
    .error_flag(error_flag)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Room for every request walking a full-length chain.
  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned effective_verts();
    if (num_verts_setting == 0) return 1;
    if (num_verts_setting > TABLE_DEPTH) return TABLE_DEPTH;
    return num_verts_setting;
  endfunction

  // Walks the copy chain of one corner, updates the shadow memory and returns
  // the remap the unit has to report.
  function automatic remap_t split_corner(input logic [INDEX_W-1:0] vertex,
                                          input logic [GROUP_W-1:0] group);
    remap_t             r;
    logic [GROUP_W-1:0] grp;
    int unsigned        nv;
    int unsigned        count;
    int unsigned        s;
    int unsigned        last_s;
    bit                 found;
    nv = effective_verts();
    grp = (group == '0) ? sgvs_pkg::ZERO_GROUP : group;
    count = nv + spare_copies;
    r.mapped = '0;
    r.new_copy = 1'b0;
    r.count = count[COUNT_W-1:0];
    r.err = 1'b1;
    found = 1'b0;
    if (vertex >= nv) return r;
    s = vertex;
    last_s = s;
    for (int steps = 0; steps <= TABLE_DEPTH; steps++) begin
      if ((kept_mask[s] & grp) != '0) begin
        found = 1'b1;
        break;
      end
      last_s = s;
      if (!link_ok[s]) break;
      s = next_copy[s];
      if (s >= TABLE_DEPTH) return r;
    end
    if (found) begin
      kept_mask[s] = kept_mask[s] & grp;
      r.mapped = s[INDEX_W-1:0];
      r.err = 1'b0;
      return r;
    end
    // A chain that never ended or a table with no free slot refuses the corner.
    if (link_ok[last_s]) return r;
    if (count >= TABLE_DEPTH) return r;
    next_copy[last_s] = count[COUNT_W-1:0];
    link_ok[last_s] = 1'b1;
    kept_mask[count] = grp;
    link_ok[count] = 1'b0;
    next_copy[count] = '0;
    spare_copies = spare_copies + 1'b1;
    r.mapped = count[INDEX_W-1:0];
    count = nv + spare_copies;
    r.new_copy = 1'b1;
    r.count = count[COUNT_W-1:0];
    r.err = 1'b0;
    return r;
  endfunction

  function automatic logic [GROUP_W-1:0] random_group_mask();
    int unsigned        pick;
    logic [GROUP_W-1:0] m;
    pick = $urandom_range(99);
    if (pick < 30) m = GROUP_W'(1) << $urandom_range(7);
    else if (pick < 55) m = (GROUP_W'(1) << $urandom_range(7)) | (GROUP_W'(1) << $urandom_range(7));
    else if (pick < 65) m = '0;
    else if (pick < 70) m = '1;
    else if (pick < 85) m = GROUP_W'(1) << $urandom_range(GROUP_W - 1);
    else m = $urandom;
    return m;
  endfunction

  function automatic logic [INDEX_W-1:0] random_vertex();
    if ($urandom_range(99) < 8) return INDEX_W'($urandom_range(TABLE_DEPTH - 1));
    return INDEX_W'($urandom_range(effective_verts() - 1));
  endfunction

  task automatic queue_corner(input logic [INDEX_W-1:0] v, input logic [GROUP_W-1:0] m);
    corners_to_send.push_back('{vertex: v, group: m});
  endtask

  // Sampled on the falling edge so that every handshake of the cycle is settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (corners_to_send.size() != 0 || in_valid || expected_remaps.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_num_verts(input logic [COUNT_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    num_verts_setting = value;
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] verts, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned items,
                           input bit long_stall);
    write_num_verts(verts);
    @(posedge clk);
    send_idle_pct <= idle_pct;
    recv_stall_pct <= stall_pct;
    @(negedge clk);
    for (int n = 0; n < items / 2; n++) queue_corner(random_vertex(), random_group_mask());
    if (long_stall) hold_trigger = 1'b1;
    // The sender rests here until every pending request has been answered.
    wait_idle();
    for (int n = items / 2; n < items; n++) queue_corner(random_vertex(), random_group_mask());
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_remaps.push_back(split_corner(vertex_index, group_mask));
      end
      if (!in_valid || in_ready) begin
        if (corners_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          launch_corner = corners_to_send.pop_front();
          in_valid <= 1'b1;
          vertex_index <= launch_corner.vertex;
          group_mask <= launch_corner.group;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_remaps.size() == 0) begin
          $error("result with no request outstanding: mapped_index %0d", mapped_index);
          fail_count++;
        end else begin
          oldest_remap = expected_remaps.pop_front();
          if (mapped_index !== oldest_remap.mapped) begin
            $error("mapped_index: expected %0d, got %0d", oldest_remap.mapped, mapped_index);
            fail_count++;
          end
          if (new_copy !== oldest_remap.new_copy) begin
            $error("new_copy: expected %0d, got %0d", oldest_remap.new_copy, new_copy);
            fail_count++;
          end
          if (vertex_count !== oldest_remap.count) begin
            $error("vertex_count: expected %0d, got %0d", oldest_remap.count, vertex_count);
            fail_count++;
          end
          if (error_flag !== oldest_remap.err) begin
            $error("error_flag: expected %0d, got %0d", oldest_remap.err, error_flag);
            fail_count++;
          end
        end
      end
      out_ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One long receiver stall while the sender keeps offering requests.
  initial begin
    do @(posedge clk);
    while (!hold_trigger);
    long_hold <= 1'b1;
    for (int n = 0; n < 400; n++) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      kept_mask[i] = '1;
      next_copy[i] = '0;
      link_ok[i] = 1'b0;
    end
    spare_copies = '0;
    num_verts_setting = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the register: one original vertex.
    @(negedge clk);
    queue_corner(12'd0, 32'h0000_0000);
    queue_corner(12'd0, 32'h0000_0001);
    queue_corner(12'd0, 32'h0000_0003);
    queue_corner(12'd0, 32'h8000_0000);
    queue_corner(12'd0, 32'hFFFF_FFFF);
    queue_corner(12'd0, 32'h0000_0002);
    queue_corner(12'd1, 32'h0000_0001);
    queue_corner(12'd4095, 32'hFFFF_FFFF);
    wait_idle();

    // A register value of zero behaves as one vertex.
    write_num_verts(13'd0);
    @(negedge clk);
    queue_corner(12'd0, 32'h4000_0000);
    queue_corner(12'd1, 32'h0000_0000);
    wait_idle();

    // Oversized register clamps to the table depth, so new copies find it full.
    write_num_verts(13'd8191);
    @(negedge clk);
    queue_corner(12'd4095, 32'h0000_0010);
    queue_corner(12'd4095, 32'h0000_0020);
    queue_corner(12'd4095, 32'h0000_0030);
    queue_corner(12'd0, 32'h0800_0000);
    queue_corner(12'd2048, 32'h0000_0000);
    queue_corner(12'd2730, 32'h5555_5555);
    wait_idle();

    run_phase(13'd16, 0, 0, 300, 1'b1);
    run_phase(13'd200, 87, 0, 300, 1'b0);
    // Shrinking the vertex count makes new copies land inside older chains.
    run_phase(13'd3, 0, 87, 300, 1'b0);
    run_phase(13'd4096, 35, 35, 300, 1'b0);
    run_phase(13'd2, 0, 0, 200, 1'b0);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_remaps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
